### rtl/ila_pkg.sv
`timescale 1ns / 1ps

package ila_pkg;

    localparam int MAX_LANES_DEF = 64;

    localparam int COORD_W   = 31;
    localparam int WIDTH_W   = 16;
    localparam int SPACE_W   = 8;
    localparam int QUERY_W   = 6;
    localparam int SUM_W     = 24;
    localparam int OFFS_W    = 25;
    localparam int KIND_W    = 2;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 31;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PLACE = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_OVERLAP = 2'd0,
        MODE_ALL     = 2'd1,
        MODE_ALT     = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE       = 3'd0,
        CFG_CLIP_START = 3'd1,
        CFG_CLIP_END   = 3'd2,
        CFG_SPACING    = 3'd3,
        CFG_SET_WIDTH  = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN
    } state_t;

    // Operands broadcast to every lane cell while a wave runs.
    typedef struct packed {
        logic [COORD_W-1:0] seg_start;
        logic [COORD_W-1:0] seg_end;
        logic [WIDTH_W-1:0] item_width;
        logic [QUERY_W-1:0] lane_query;
        logic [SPACE_W-1:0] spacing;
    } lane_op_t;

    // Token handed from cell to cell.
    typedef struct packed {
        logic               valid;
        logic               is_query;
        logic               claimed;
        logic               stopped;
        logic [SUM_W-1:0]   acc;
        logic [SUM_W-1:0]   prefix;
        logic [WIDTH_W-1:0] lane_width;
    } wave_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [WIDTH_W:0]  b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(b);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

### rtl/ila_lane_cell.sv
`timescale 1ns / 1ps

module ila_lane_cell #(
    parameter int LANE_IDX = 0,
    parameter int LANE_W   = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   clear,
    input  ila_pkg::lane_op_t      op,
    input  ila_pkg::wave_t         wave_in,
    input  logic [LANE_W-1:0]      lane_in,
    output ila_pkg::wave_t         wave_out,
    output logic [LANE_W-1:0]      lane_out
);
    import ila_pkg::*;

    logic [COORD_W-1:0] last_end_reg, last_end_next;
    logic               in_use_reg, in_use_next;
    logic [WIDTH_W-1:0] max_width_reg, max_width_next;
    wave_t              wave_reg, wave_next;
    logic [LANE_W-1:0]  lane_reg, lane_next;

    logic free;
    logic hit;
    logic is_me;

    assign free  = !in_use_reg || (last_end_reg < op.seg_start);
    assign hit   = wave_in.valid && !wave_in.is_query && !wave_in.claimed && free;
    assign is_me = (32'(op.lane_query) == 32'(LANE_IDX));

    // Claim on a place wave, accumulate the prefix on a query wave.
    always_comb
    begin
        wave_next = wave_in;
        lane_next = lane_in;
        if (hit)
        begin
            wave_next.claimed = 1'b1;
            lane_next         = LANE_W'(LANE_IDX);
        end
        if (wave_in.valid && wave_in.is_query)
        begin
            if (is_me)
            begin
                wave_next.lane_width = max_width_reg;
            end
            if (!wave_in.stopped)
            begin
                if (max_width_reg == '0)
                begin
                    wave_next.stopped = 1'b1;
                end
                else
                begin
                    if (is_me)
                    begin
                        wave_next.prefix = wave_in.acc;
                    end
                    wave_next.acc = sat_add(wave_in.acc,
                                            {1'b0, max_width_reg} + (WIDTH_W+1)'(op.spacing));
                end
            end
        end
    end

    always_comb
    begin
        last_end_next  = last_end_reg;
        in_use_next    = in_use_reg;
        max_width_next = max_width_reg;
        if (clear)
        begin
            last_end_next  = '0;
            in_use_next    = 1'b0;
            max_width_next = '0;
        end
        else if (hit)
        begin
            last_end_next = op.seg_end;
            in_use_next   = 1'b1;
            if (max_width_reg < op.item_width)
            begin
                max_width_next = op.item_width;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_end_reg  <= '0;
            in_use_reg    <= 1'b0;
            max_width_reg <= '0;
            wave_reg      <= '0;
            lane_reg      <= '0;
        end
        else
        begin
            last_end_reg  <= last_end_next;
            in_use_reg    <= in_use_next;
            max_width_reg <= max_width_next;
            wave_reg      <= wave_next;
            lane_reg      <= lane_next;
        end
    end

    assign wave_out = wave_reg;
    assign lane_out = lane_reg;

endmodule

### rtl/interval_lane_assigner_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// input     in         start / busy              kind, seg_start, seg_end, item_width,
//                                                masked, lane_query
// result    out        done (one-cycle strobe)   visible, lane, run_offset, full_res,
//                                                lane_width, lane_offset, total_width,
//                                                widest_extent
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Flow: a hidden interval, a mode 1/2/3 placement, a clear or an unused kind
// gives its result straight from evaluation; a mode 0 placement or a query
// sends a token down the row of MAX_LANES lane cells, one cell per cycle, and
// gives its result once the token leaves the last cell. One item at a time.
// Reset: rst_n clears all lanes, sums, state and configuration at once; no clearing pass.
// Stalls: none on the result side; busy holds off new items, cfg_ready is always high.
module interval_lane_assigner_top #(
    parameter int MAX_LANES = ila_pkg::MAX_LANES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input items
    input  logic                                start,
    output logic                                busy,
    input  logic [ila_pkg::KIND_W-1:0]          kind,
    input  logic [ila_pkg::COORD_W-1:0]         seg_start,
    input  logic [ila_pkg::COORD_W-1:0]         seg_end,
    input  logic [ila_pkg::WIDTH_W-1:0]         item_width,
    input  logic                                masked,
    input  logic [ila_pkg::QUERY_W-1:0]         lane_query,
    // results
    output logic                                done,
    output logic                                visible,
    output logic [ila_pkg::QUERY_W-1:0]         lane,
    output logic [ila_pkg::SUM_W-1:0]           run_offset,
    output logic                                full_res,
    output logic [ila_pkg::WIDTH_W-1:0]         lane_width,
    output logic signed [ila_pkg::OFFS_W-1:0]   lane_offset,
    output logic [ila_pkg::SUM_W-1:0]           total_width,
    output logic [ila_pkg::COORD_W-1:0]         widest_extent,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ila_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ila_pkg::CFG_DAT_W-1:0]       cfg_data
);
    import ila_pkg::*;

    localparam int LANE_W = $clog2(MAX_LANES);

    // Configuration registers.
    logic [MODE_W-1:0]  mode_reg;
    logic [COORD_W-1:0] clip_start_reg;
    logic [COORD_W-1:0] clip_end_reg;
    logic [SPACE_W-1:0] spacing_reg;
    logic [WIDTH_W-1:0] set_width_reg;

    // Control and captured operands.
    state_t             state_reg, state_next;
    logic [KIND_W-1:0]  kind_reg;
    logic [COORD_W-1:0] s_reg, e_reg;
    logic [WIDTH_W-1:0] w_reg;
    logic               masked_reg;
    logic [QUERY_W-1:0] q_reg;

    // Running state outside the lanes.
    logic [SUM_W-1:0]   running_reg, running_next;
    logic [COORD_W-1:0] extent_reg, extent_next;

    // Result registers.
    logic               done_reg, done_next;
    logic               visible_reg, visible_next;
    logic [QUERY_W-1:0] lane_reg, lane_next;
    logic [SUM_W-1:0]   run_offset_reg, run_offset_next;
    logic               full_reg, full_next;
    logic [WIDTH_W-1:0] lane_width_reg, lane_width_next;
    logic [OFFS_W-1:0]  lane_offset_reg, lane_offset_next;
    logic [SUM_W-1:0]   total_reg, total_next;
    logic [COORD_W-1:0] extent_out_reg, extent_out_next;

    logic accept;
    logic shown;
    logic launch;
    logic clear_lanes;
    logic [COORD_W-1:0] ext_len;
    logic [COORD_W-1:0] ext_new;
    logic [WIDTH_W:0]   alt_incr;
    logic [WIDTH_W:0]   all_incr;

    logic signed [WIDTH_W+1:0] width_diff;
    logic signed [WIDTH_W+1:0] half_diff;
    logic signed [OFFS_W:0]    offs_raw;

    lane_op_t           op;
    wave_t              wave_link [0:MAX_LANES];
    logic [LANE_W-1:0]  lane_link [0:MAX_LANES];
    wave_t              wave_tail;
    logic [LANE_W-1:0]  lane_tail;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // Visible when inside the clip window and not masked.
    assign shown = !((e_reg < clip_start_reg) || (s_reg > clip_end_reg) || masked_reg);

    assign launch = (state_reg == ST_EVAL) &&
                    ((kind_reg == KIND_QUERY) ||
                     ((kind_reg == KIND_PLACE) && shown && (mode_reg == MODE_OVERLAP)));

    assign clear_lanes = (state_reg == ST_EVAL) && (kind_reg == KIND_CLEAR);

    // Extent of a reversed or empty interval counts as zero.
    assign ext_len = (e_reg > s_reg) ? (e_reg - s_reg) : '0;
    assign ext_new = (ext_len > extent_reg) ? ext_len : extent_reg;

    assign alt_incr = {1'b0, set_width_reg} + (WIDTH_W+1)'(spacing_reg);
    assign all_incr = {1'b0, w_reg} + (WIDTH_W+1)'(spacing_reg);

    // ---------------------------------------------------------------------
    // Lane chain: the token enters cell 0 while evaluating and moves through
    // one registered cell per lane before it leaves the last cell.
    // ---------------------------------------------------------------------
    assign op.seg_start  = s_reg;
    assign op.seg_end    = e_reg;
    assign op.item_width = w_reg;
    assign op.lane_query = q_reg;
    assign op.spacing    = spacing_reg;

    always_comb
    begin
        wave_link[0]          = '0;
        wave_link[0].valid    = launch;
        wave_link[0].is_query = (kind_reg == KIND_QUERY);
        lane_link[0]          = '0;
    end

    for (genvar gi = 0; gi < MAX_LANES; gi++)
    begin : g_lane
        ila_lane_cell #(
            .LANE_IDX (gi),
            .LANE_W   (LANE_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (clear_lanes),
            .op       (op),
            .wave_in  (wave_link[gi]),
            .lane_in  (lane_link[gi]),
            .wave_out (wave_link[gi+1]),
            .lane_out (lane_link[gi+1])
        );
    end

    assign wave_tail = wave_link[MAX_LANES];
    assign lane_tail = lane_link[MAX_LANES];

    // Centered offset: prefix minus floor((set_width - lane_width) / 2).
    assign width_diff = $signed({2'b00, set_width_reg}) - $signed({2'b00, wave_tail.lane_width});
    assign half_diff  = width_diff >>> 1;
    assign offs_raw   = $signed({2'b00, wave_tail.prefix}) -
                        $signed({{(OFFS_W-WIDTH_W-1){half_diff[WIDTH_W+1]}}, half_diff});

    // ---------------------------------------------------------------------
    // Sequencer: next state.
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = launch ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (wave_tail.valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer: results and running sums.
    // ---------------------------------------------------------------------
    always_comb
    begin
        done_next        = 1'b0;
        visible_next     = visible_reg;
        lane_next        = lane_reg;
        run_offset_next  = run_offset_reg;
        full_next        = full_reg;
        lane_width_next  = lane_width_reg;
        lane_offset_next = lane_offset_reg;
        total_next       = total_reg;
        extent_out_next  = extent_out_reg;
        running_next     = running_reg;
        extent_next      = extent_reg;

        unique case (state_reg)
            ST_EVAL:
            begin
                // Clear every field first; each arm fills in what it gives.
                visible_next     = 1'b0;
                lane_next        = '0;
                run_offset_next  = '0;
                full_next        = 1'b0;
                lane_width_next  = '0;
                lane_offset_next = '0;
                total_next       = '0;
                extent_out_next  = '0;
                unique case (kind_reg)
                    KIND_PLACE:
                    begin
                        if (!shown)
                        begin
                            done_next       = 1'b1;
                            extent_out_next = extent_reg;
                        end
                        else
                        begin
                            extent_next = ext_new;
                            if (mode_reg != MODE_OVERLAP)
                            begin
                                done_next       = 1'b1;
                                visible_next    = 1'b1;
                                extent_out_next = ext_new;
                            end
                            unique case (mode_reg)
                                MODE_ALL:
                                begin
                                    run_offset_next = running_reg;
                                    running_next    = sat_add(running_reg, all_incr);
                                end
                                MODE_ALT:
                                begin
                                    run_offset_next = running_reg;
                                    running_next    = (running_reg > SUM_W'(alt_incr)) ? '0 :
                                                      (SUM_W'(alt_incr) - running_reg);
                                end
                                default:
                                begin
                                    running_next = running_reg;
                                end
                            endcase
                        end
                    end
                    KIND_QUERY:
                    begin
                        done_next = 1'b0;
                    end
                    KIND_CLEAR:
                    begin
                        done_next    = 1'b1;
                        running_next = '0;
                        extent_next  = '0;
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (wave_tail.valid)
                begin
                    done_next        = 1'b1;
                    extent_out_next  = extent_reg;
                    visible_next     = 1'b0;
                    lane_next        = '0;
                    run_offset_next  = '0;
                    full_next        = 1'b0;
                    lane_width_next  = '0;
                    lane_offset_next = '0;
                    total_next       = '0;
                    if (wave_tail.is_query)
                    begin
                        lane_width_next = wave_tail.lane_width;
                        total_next      = wave_tail.acc;
                        // Only the upper bound can be crossed.
                        if (!offs_raw[OFFS_W] && offs_raw[OFFS_W-1])
                        begin
                            lane_offset_next = {1'b0, {(OFFS_W-1){1'b1}}};
                        end
                        else
                        begin
                            lane_offset_next = offs_raw[OFFS_W-1:0];
                        end
                    end
                    else
                    begin
                        visible_next = 1'b1;
                        full_next    = !wave_tail.claimed;
                        lane_next    = wave_tail.claimed ? QUERY_W'(lane_tail) : '0;
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Registers.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            running_reg <= '0;
            extent_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            running_reg <= running_next;
            extent_reg  <= extent_next;
        end
    end

    // Payload registers: capture on transfer, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind;
            s_reg      <= seg_start;
            e_reg      <= seg_end;
            w_reg      <= item_width;
            masked_reg <= masked;
            q_reg      <= lane_query;
        end
        visible_reg     <= visible_next;
        lane_reg        <= lane_next;
        run_offset_reg  <= run_offset_next;
        full_reg        <= full_next;
        lane_width_reg  <= lane_width_next;
        lane_offset_reg <= lane_offset_next;
        total_reg       <= total_next;
        extent_out_reg  <= extent_out_next;
    end

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_OVERLAP;
            clip_start_reg <= '0;
            clip_end_reg   <= '1;
            spacing_reg    <= '0;
            set_width_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MODE:       mode_reg       <= cfg_data[MODE_W-1:0];
                CFG_CLIP_START: clip_start_reg <= cfg_data[COORD_W-1:0];
                CFG_CLIP_END:   clip_end_reg   <= cfg_data[COORD_W-1:0];
                CFG_SPACING:    spacing_reg    <= cfg_data[SPACE_W-1:0];
                CFG_SET_WIDTH:  set_width_reg  <= cfg_data[WIDTH_W-1:0];
                default:        mode_reg       <= mode_reg;
            endcase
        end
    end

    assign done          = done_reg;
    assign visible       = visible_reg;
    assign lane          = lane_reg;
    assign run_offset    = run_offset_reg;
    assign full_res      = full_reg;
    assign lane_width    = lane_width_reg;
    assign lane_offset   = $signed(lane_offset_reg);
    assign total_width   = total_reg;
    assign widest_extent = extent_out_reg;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without an item in work");

    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EVAL))
        else $error("transfer did not start evaluation");

    a_token_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wave_tail.valid |-> (state_reg == ST_SCAN))
        else $error("lane token left the chain outside a scan");

    a_full_only_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (done && full_res) |-> (visible && (mode_reg == MODE_OVERLAP)))
        else $error("full flag outside an overlap placement");

endmodule
